// ===== hdl/mema_pkg.sv =====
`timescale 1ns / 1ps

package mema_pkg;

  localparam int NUM_CHANNELS = 8;

  localparam int CHANNEL_W = 3;
  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 24;
  localparam int FRAC_W    = 8;
  localparam int WEIGHT_W  = 9;
  localparam int DZONE_W   = 24;
  localparam int OFFSET_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 9'd26;
  localparam logic [DZONE_W-1:0]  DZONE_RESET   = 24'd1280;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET  = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTHING_WEIGHT = 2'd0,
    CFG_DEAD_ZONE        = 2'd1,
    CFG_OUTPUT_OFFSET    = 2'd2
  } cfg_idx_t;

  typedef logic [LEVEL_W-1:0] level_t;

endpackage

// ===== hdl/mema_in_if.sv =====
`timescale 1ns / 1ps

interface mema_in_if
  import mema_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [SAMPLE_W-1:0]  sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ===== hdl/mema_out_if.sv =====
`timescale 1ns / 1ps

interface mema_out_if
  import mema_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel_out;
  logic [SAMPLE_W-1:0]  level;
  logic                 updated;

  modport source (output valid, output channel_out, output level, output updated,
                  input ready);
  modport sink   (input valid, input channel_out, input level, input updated,
                  output ready);
endinterface

// ===== hdl/mema_cfg_if.sv =====
`timescale 1ns / 1ps

interface mema_cfg_if
  import mema_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/multichannel_ema_dead_band_smoother.sv =====
`timescale 1ns / 1ps

// Per-channel exponential moving average with a dead band.
// in_port  : one transaction carries a channel number and a 16-bit sample.
// out_port : one transaction per input transaction, in order: the channel,
//            its integer level minus output_offset (floored at zero), and
//            a flag set when the stored level moved.
// cfg_port : register writes (0 weight Q1.8, 1 dead zone Q16.8, 2 offset),
//            always ready; writes must be issued by the user only while the
//            block is idle, which the block itself does not enforce.
// A result passes the input register, then the update and result register.
// Throughput is one transaction per cycle when the receiver does not stall;
// the stored levels sit in flops and each update is read, changed and
// written in the same cycle, so a sample for the same channel may follow
// directly. Reset clears all eight levels to zero, loads the register
// defaults (26, 1280, 100) and empties both stages.
// When the receiver stalls, the result register holds and the input
// register still takes one more transaction; after that in_port.ready drops.
module multichannel_ema_dead_band_smoother
  import mema_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  mema_in_if.sink     in_port,
  mema_out_if.source  out_port,
  mema_cfg_if.sink    cfg_port
);

  logic [WEIGHT_W-1:0]  weight_r;
  logic [DZONE_W-1:0]   dzone_r;
  logic [OFFSET_W-1:0]  offset_r;

  level_t               levels_r [NUM_CHANNELS];

  logic                 s1_valid_r;
  logic [CHANNEL_W-1:0] s1_channel_r;
  logic [SAMPLE_W-1:0]  s1_sample_r;

  logic                 out_valid_r;
  logic [CHANNEL_W-1:0] out_channel_r;
  logic [SAMPLE_W-1:0]  out_level_r;
  logic                 out_updated_r;

  logic                 out_free;
  logic                 advance;
  logic                 accept;
  logic                 chan_ok;
  logic [WEIGHT_W-1:0]  w_c;
  level_t               cur_c;
  level_t               target_c;
  logic                 up_c;
  level_t               mag_c;
  logic [LEVEL_W+WEIGHT_W-1:0] prod_c;
  level_t               step_c;
  level_t               cand_c;
  logic                 upd_c;
  level_t               new_c;
  logic [SAMPLE_W-1:0]  whole_c;
  logic [SAMPLE_W-1:0]  level_nxt;

  assign out_free         = !out_valid_r || out_port.ready;
  assign advance          = s1_valid_r && out_free;
  assign in_port.ready    = !s1_valid_r || out_free;
  assign accept           = in_port.valid && in_port.ready;
  assign cfg_port.ready   = 1'b1;

  assign out_port.valid       = out_valid_r;
  assign out_port.channel_out = out_channel_r;
  assign out_port.level       = out_level_r;
  assign out_port.updated     = out_updated_r;

  always_comb begin
    chan_ok  = 32'(s1_channel_r) < NUM_CHANNELS;
    w_c      = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
    cur_c    = chan_ok ? levels_r[s1_channel_r] : '0;
    target_c = {s1_sample_r, {FRAC_W{1'b0}}};
    up_c     = target_c >= cur_c;
    mag_c    = up_c ? (target_c - cur_c) : (cur_c - target_c);
    prod_c   = (LEVEL_W+WEIGHT_W)'(mag_c) * (LEVEL_W+WEIGHT_W)'(w_c);
    step_c   = prod_c[LEVEL_W+FRAC_W-1:FRAC_W];
    cand_c   = up_c ? (cur_c + step_c) : (cur_c - step_c);
    upd_c    = chan_ok && (step_c > dzone_r);
    new_c    = upd_c ? cand_c : cur_c;
    whole_c  = new_c[LEVEL_W-1:FRAC_W];
    if (!chan_ok) begin
      level_nxt = '0;
    end else if (whole_c > offset_r) begin
      level_nxt = whole_c - offset_r;
    end else begin
      level_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RESET;
      dzone_r  <= DZONE_RESET;
      offset_r <= OFFSET_RESET;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        CFG_SMOOTHING_WEIGHT: weight_r <= cfg_port.data[WEIGHT_W-1:0];
        CFG_DEAD_ZONE:        dzone_r  <= cfg_port.data[DZONE_W-1:0];
        CFG_OUTPUT_OFFSET:    offset_r <= cfg_port.data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        levels_r[i] <= '0;
      end
    end else if (advance && upd_c) begin
      levels_r[s1_channel_r] <= cand_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_channel_r <= in_port.channel;
      s1_sample_r  <= in_port.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_r <= s1_channel_r;
      out_level_r   <= level_nxt;
      out_updated_r <= upd_c;
    end
  end

  a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> step_c <= mag_c)
    else $error("step exceeds distance to sample");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_channel_r)
      && $stable(s1_sample_r))
    else $error("input stage lost a transaction during stall");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r && out_channel_r == $past(s1_channel_r))
    else $error("result register not loaded on advance");

  a_not_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_port.ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled while a stage is empty");

  a_no_update_in_dead_zone: assert property (@(posedge clk) disable iff (!rst_n)
    advance && step_c <= dzone_r |=> !out_updated_r)
    else $error("level stored inside dead zone");

endmodule
